// ===== hw/rtl/brle_pkg.sv =====
// Shared constants, segment command type and helpers for the byte run-length encoder.
// No dependencies; every other file but brle_ram imports this package.
package brle_pkg;

    localparam int LITERAL_MAX = 128;
    localparam int OUT_LANES   = 8;
    localparam int REPEAT_MAX  = 129;
    localparam int RING_DEPTH  = 2 * LITERAL_MAX;
    localparam int RING_AW     = $clog2(RING_DEPTH);
    localparam int OCC_W       = RING_AW + 1;
    localparam int LEN_W       = 8;
    localparam int LANE_AW     = (OUT_LANES > 1) ? $clog2(OUT_LANES) : 1;
    localparam int CNT_W       = 4;
    localparam int WORD_W      = 8 * OUT_LANES;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] REPEAT_BASE = 8'd126;

    typedef enum logic
    {
        SEG_LIT,
        SEG_REP
    } seg_kind_t;

    typedef enum logic
    {
        PH_HEAD,
        PH_DATA
    } back_phase_t;

    typedef struct packed
    {
        seg_kind_t            kind;
        logic [7:0]           header;
        logic [7:0]           value;
        logic [RING_AW-1:0]   addr;
        logic [LEN_W-1:0]     len;
        logic                 last;
    } seg_t;

    function automatic seg_t mk_lit(input logic [LEN_W-1:0] len, input logic [RING_AW-1:0] addr);
        seg_t s;
        s        = '0;
        s.kind   = SEG_LIT;
        s.header = 8'(len - LEN_W'(1));
        s.addr   = addr;
        s.len    = len;
        return s;
    endfunction

    function automatic seg_t mk_rep(input logic [LEN_W-1:0] len, input logic [7:0] value);
        seg_t s;
        s        = '0;
        s.kind   = SEG_REP;
        s.header = REPEAT_BASE + 8'(len);
        s.value  = value;
        s.len    = LEN_W'(1);
        return s;
    endfunction

endpackage

// ===== hw/rtl/byte_run_length_encoder_core.sv =====
// Byte run-length encoder top level: front end, command queue, literal ring RAM, back end.
// Throughput: the back end emits one encoded byte per cycle while word_ready does not stall it,
// so requests are taken only as fast as the encoded bytes they cause are emitted: a literal
// stream adds one header byte per 128 literal bytes.
// Reset: asynchronous, clears all run state and queues; the literal ring needs no clearing.
module byte_run_length_encoder_core
    import brle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        data_byte,
    input  logic              end_of_stream,
    input  logic              data_valid,
    output logic              data_ready,
    output logic [WORD_W-1:0] packed_bytes,
    output logic [CNT_W-1:0]  byte_count,
    output logic              last_word,
    output logic              word_valid,
    input  logic              word_ready
);

    logic [QUEUE_AW:0]  queue_free;
    logic [1:0]         push_cnt;
    seg_t               push0;
    seg_t               push1;
    seg_t               head;
    logic               head_valid;
    logic               pop;
    logic               ring_we;
    logic [RING_AW-1:0] ring_waddr;
    logic [7:0]         ring_wdata;
    logic               ring_re;
    logic [RING_AW-1:0] ring_raddr;
    logic [7:0]         ring_rdata;
    logic               ring_release;

    brle_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .data_valid    (data_valid),
        .data_ready    (data_ready),
        .queue_free    (queue_free),
        .push_cnt      (push_cnt),
        .push0         (push0),
        .push1         (push1),
        .ring_we       (ring_we),
        .ring_waddr    (ring_waddr),
        .ring_wdata    (ring_wdata),
        .ring_release  (ring_release)
    );

    brle_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push0      (push0),
        .push1      (push1),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .free       (queue_free)
    );

    brle_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .re    (ring_re),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    brle_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .head_valid   (head_valid),
        .pop          (pop),
        .ring_re      (ring_re),
        .ring_raddr   (ring_raddr),
        .ring_rdata   (ring_rdata),
        .ring_release (ring_release),
        .packed_bytes (packed_bytes),
        .byte_count   (byte_count),
        .last_word    (last_word),
        .word_valid   (word_valid),
        .word_ready   (word_ready)
    );

endmodule

// ===== hw/rtl/brle_ram.sv =====
// Generic single-write, single-read RAM with registered read data and read enable.
// No dependencies.
module brle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/brle_front.sv =====
// Front end: accepts raw byte requests, tracks run state, writes literal bytes to the ring
// and issues up to two segment commands per request. Depends on brle_pkg.
module brle_front
    import brle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  logic               end_of_stream,
    input  logic               data_valid,
    output logic               data_ready,
    input  logic [QUEUE_AW:0]  queue_free,
    output logic [1:0]         push_cnt,
    output seg_t               push0,
    output seg_t               push1,
    output logic               ring_we,
    output logic [RING_AW-1:0] ring_waddr,
    output logic [7:0]         ring_wdata,
    input  logic               ring_release
);

    logic [RING_AW-1:0] lit_start_reg, lit_start_next;
    logic [LEN_W-1:0]   lit_len_reg, lit_len_next;
    logic [7:0]         held_reg, held_next;
    logic               in_rep_reg, in_rep_next;
    logic [LEN_W-1:0]   rep_len_reg, rep_len_next;
    logic [RING_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OCC_W-1:0]   occ_reg, occ_next;

    logic               take;
    logic               eq;
    logic [LEN_W-1:0]   rep_inc;
    logic               start_lit;
    logic               wr_en;
    logic               drop;
    seg_t               seg_a;
    seg_t               seg_f;
    logic               seg_a_v;
    logic               seg_f_v;

    assign data_ready = (queue_free >= (QUEUE_AW + 1)'(2)) && (occ_reg < OCC_W'(RING_DEPTH));
    assign take       = data_valid && data_ready;
    assign eq         = (data_byte == held_reg);
    assign rep_inc    = rep_len_reg + LEN_W'(1);

    always_comb
    begin
        lit_start_next = lit_start_reg;
        lit_len_next   = lit_len_reg;
        held_next      = held_reg;
        in_rep_next    = in_rep_reg;
        rep_len_next   = rep_len_reg;
        wr_ptr_next    = wr_ptr_reg;
        start_lit      = 1'b0;
        wr_en          = 1'b0;
        drop           = 1'b0;
        seg_a          = '0;
        seg_a_v        = 1'b0;
        seg_f          = '0;
        seg_f_v        = 1'b0;

        if (take)
        begin
            if (in_rep_reg)
            begin
                if (eq)
                begin
                    rep_len_next = rep_inc;
                    if (rep_inc == LEN_W'(REPEAT_MAX))
                    begin
                        seg_a        = mk_rep(rep_inc, held_reg);
                        seg_a_v      = 1'b1;
                        in_rep_next  = 1'b0;
                        rep_len_next = '0;
                    end
                end
                else
                begin
                    seg_a        = mk_rep(rep_len_reg, held_reg);
                    seg_a_v      = 1'b1;
                    in_rep_next  = 1'b0;
                    rep_len_next = '0;
                    start_lit    = 1'b1;
                end
            end
            else if (lit_len_reg == '0)
            begin
                start_lit = 1'b1;
            end
            else if (eq)
            begin
                if (lit_len_reg > LEN_W'(1))
                begin
                    seg_a   = mk_lit(lit_len_reg - LEN_W'(1), lit_start_reg);
                    seg_a_v = 1'b1;
                end
                drop         = 1'b1;
                lit_len_next = '0;
                in_rep_next  = 1'b1;
                rep_len_next = LEN_W'(2);
            end
            else if (lit_len_reg >= LEN_W'(LITERAL_MAX))
            begin
                seg_a     = mk_lit(LEN_W'(LITERAL_MAX), lit_start_reg);
                seg_a_v   = 1'b1;
                start_lit = 1'b1;
            end
            else
            begin
                wr_en        = 1'b1;
                lit_len_next = lit_len_reg + LEN_W'(1);
                held_next    = data_byte;
            end

            if (start_lit)
            begin
                wr_en          = 1'b1;
                lit_start_next = wr_ptr_reg;
                lit_len_next   = LEN_W'(1);
                held_next      = data_byte;
            end

            if (wr_en)
            begin
                wr_ptr_next = wr_ptr_reg + RING_AW'(1);
            end
            else if (drop)
            begin
                wr_ptr_next = wr_ptr_reg - RING_AW'(1);
            end

            if (end_of_stream)
            begin
                if (in_rep_next)
                begin
                    seg_f   = mk_rep(rep_len_next, held_next);
                    seg_f_v = 1'b1;
                end
                else if (lit_len_next != '0)
                begin
                    seg_f   = mk_lit(lit_len_next, lit_start_next);
                    seg_f_v = 1'b1;
                end
                lit_len_next = '0;
                in_rep_next  = 1'b0;
                rep_len_next = '0;
                held_next    = '0;
            end
        end

        occ_next = occ_reg + OCC_W'(wr_en) - OCC_W'(drop) - OCC_W'(ring_release);
    end

    always_comb
    begin
        push0    = seg_a_v ? seg_a : seg_f;
        push1    = seg_f;
        push_cnt = 2'(seg_a_v) + 2'(seg_f_v);
        if (seg_a_v && seg_f_v)
        begin
            push0.last = 1'b0;
            push1.last = 1'b1;
        end
        else
        begin
            push0.last = 1'b1;
            push1.last = 1'b0;
        end
    end

    assign ring_we    = wr_en;
    assign ring_waddr = wr_ptr_reg;
    assign ring_wdata = data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lit_start_reg <= '0;
            lit_len_reg   <= '0;
            held_reg      <= '0;
            in_rep_reg    <= 1'b0;
            rep_len_reg   <= '0;
            wr_ptr_reg    <= '0;
            occ_reg       <= '0;
        end
        else
        begin
            lit_start_reg <= lit_start_next;
            lit_len_reg   <= lit_len_next;
            held_reg      <= held_next;
            in_rep_reg    <= in_rep_next;
            rep_len_reg   <= rep_len_next;
            wr_ptr_reg    <= wr_ptr_next;
            occ_reg       <= occ_next;
        end
    end

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(RING_DEPTH))
        else $error("ring occupancy beyond depth");

    a_lit_xor_rep: assert property (@(posedge clk) disable iff (!rst_n)
        in_rep_reg |-> (lit_len_reg == '0))
        else $error("literal pending during repeat run");

endmodule

// ===== hw/rtl/brle_cmd_queue.sv =====
// Short register queue of segment commands between front and back end.
// Takes up to two pushes and one pop per cycle. Depends on brle_pkg.
module brle_cmd_queue
    import brle_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  seg_t              push0,
    input  seg_t              push1,
    input  logic              pop,
    output seg_t              head,
    output logic              head_valid,
    output logic [QUEUE_AW:0] free
);

    seg_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + (QUEUE_AW + 1)'(push_cnt) - (QUEUE_AW + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            slot_reg[wr_ptr_reg + QUEUE_AW'(1)] <= push1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head       = slot_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign free       = (QUEUE_AW + 1)'(QUEUE_DEPTH) - count_reg;

endmodule

// ===== hw/rtl/brle_back.sv =====
// Back end: walks segment commands one encoded byte per cycle unless the output stalls, reads literal bytes
// from the ring and packs bytes into output words. Depends on brle_pkg.
module brle_back
    import brle_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  seg_t               head,
    input  logic               head_valid,
    output logic               pop,
    output logic               ring_re,
    output logic [RING_AW-1:0] ring_raddr,
    input  logic [7:0]         ring_rdata,
    output logic               ring_release,
    output logic [WORD_W-1:0]  packed_bytes,
    output logic [CNT_W-1:0]   byte_count,
    output logic               last_word,
    output logic               word_valid,
    input  logic               word_ready
);

    back_phase_t        phase_reg, phase_next;
    logic [LEN_W-1:0]   rem_reg, rem_next;
    logic [RING_AW-1:0] addr_reg, addr_next;

    logic               q_v_reg, q_ram_reg, q_end_reg;
    logic [7:0]         q_byte_reg;
    logic [WORD_W-1:0]  acc_reg;
    logic [LANE_AW-1:0] acc_cnt_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               last_reg;
    logic               valid_reg;

    logic               tok_v, tok_ram, tok_end;
    logic [7:0]         tok_byte;
    logic               go;
    logic               complete;
    logic [7:0]         q_data;
    logic [WORD_W-1:0]  merged;

    assign q_data   = q_ram_reg ? ring_rdata : q_byte_reg;
    assign complete = q_v_reg && ((acc_cnt_reg == LANE_AW'(OUT_LANES - 1)) || q_end_reg);
    assign go       = !(complete && valid_reg && !word_ready);

    always_comb
    begin
        merged = acc_reg;
        merged[acc_cnt_reg * 8 +: 8] = q_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEAD;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        phase_next   = phase_reg;
        rem_next     = rem_reg;
        addr_next    = addr_reg;
        tok_v        = 1'b0;
        tok_ram      = 1'b0;
        tok_end      = 1'b0;
        tok_byte     = '0;
        pop          = 1'b0;
        ring_re      = 1'b0;
        ring_release = 1'b0;

        case (phase_reg)
            PH_HEAD:
            begin
                if (head_valid && go)
                begin
                    tok_v      = 1'b1;
                    tok_byte   = head.header;
                    rem_next   = head.len;
                    addr_next  = head.addr;
                    phase_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (go)
                begin
                    tok_v = 1'b1;
                    if (head.kind == SEG_REP)
                    begin
                        tok_byte = head.value;
                    end
                    else
                    begin
                        tok_ram      = 1'b1;
                        ring_re      = 1'b1;
                        ring_release = 1'b1;
                    end
                    addr_next = addr_reg + RING_AW'(1);
                    rem_next  = rem_reg - LEN_W'(1);
                    if (rem_reg == LEN_W'(1))
                    begin
                        tok_end    = head.last;
                        pop        = 1'b1;
                        phase_next = PH_HEAD;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HEAD;
            end
        endcase
    end

    assign ring_raddr = addr_reg;

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        addr_reg <= addr_next;
        if (go)
        begin
            q_ram_reg  <= tok_ram;
            q_byte_reg <= tok_byte;
            q_end_reg  <= tok_end;
        end
        if (q_v_reg && go && complete)
        begin
            word_reg  <= merged;
            count_reg <= CNT_W'(acc_cnt_reg) + CNT_W'(1);
            last_reg  <= q_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_v_reg     <= 1'b0;
            acc_reg     <= '0;
            acc_cnt_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                q_v_reg <= tok_v;
            end
            if (q_v_reg && go)
            begin
                if (complete)
                begin
                    acc_reg     <= '0;
                    acc_cnt_reg <= '0;
                end
                else
                begin
                    acc_reg     <= merged;
                    acc_cnt_reg <= acc_cnt_reg + LANE_AW'(1);
                end
            end
            valid_reg <= (valid_reg && !word_ready) || (complete && go);
        end
    end

    assign packed_bytes = word_reg;
    assign byte_count   = count_reg;
    assign last_word    = last_reg;
    assign word_valid   = valid_reg;

    a_pop_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty command queue");

    a_read_lit: assert property (@(posedge clk) disable iff (!rst_n)
        ring_re |-> (head_valid && head.kind == SEG_LIT))
        else $error("ring read outside literal segment");

    a_full_word: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && !last_word) |-> (byte_count == CNT_W'(OUT_LANES)))
        else $error("short word before end of request");

    a_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> head_valid)
        else $error("data phase without command");

endmodule

// ===== tb/sv/byte_run_length_encoder_core_test.sv =====
// Self-checking testbench for byte_run_length_encoder_core: byte streams go in, encoded words
// come out and are checked against a run-length predictor kept alongside the stimulus.
// Depends on brle_pkg and the encoder core RTL only.
module byte_run_length_encoder_core_test
    import brle_pkg::*;
();

    typedef struct
    {
        logic [WORD_W-1:0] lanes;
        logic [CNT_W-1:0]  count;
        logic              last;
    } word_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic [7:0]        data_byte     = 8'h00;
    logic              end_of_stream = 1'b0;
    logic              data_valid    = 1'b0;
    logic              data_ready;
    logic [WORD_W-1:0] packed_bytes;
    logic [CNT_W-1:0]  byte_count;
    logic              last_word;
    logic              word_valid;
    logic              word_ready    = 1'b0;

    int send_gap_pct    = 0;
    int ready_stall_pct = 0;
    int requests_sent   = 0;
    int streams_sent    = 0;
    int words_seen      = 0;
    int fault_count     = 0;

    logic [7:0] lit_buf [LITERAL_MAX];
    int         lit_len  = 0;
    int         rep_len  = 0;
    logic [7:0] held     = 8'h00;
    logic       in_rep   = 1'b0;
    logic [7:0] enc_q[$];
    word_t      pending_words[$];

    byte_run_length_encoder_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .data_valid    (data_valid),
        .data_ready    (data_ready),
        .packed_bytes  (packed_bytes),
        .byte_count    (byte_count),
        .last_word     (last_word),
        .word_valid    (word_valid),
        .word_ready    (word_ready)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        word_ready <= ($urandom_range(0, 99) >= ready_stall_pct);
    end

    function automatic void put_literal(input int n);
        if (n == 0)
            return;
        enc_q.push_back(8'(n - 1));
        for (int k = 0; k < n; k++)
            enc_q.push_back(lit_buf[k]);
    endfunction

    function automatic void put_repeat();
        enc_q.push_back(REPEAT_BASE + 8'(rep_len));
        enc_q.push_back(held);
        in_rep  = 1'b0;
        rep_len = 0;
    endfunction

    function automatic void open_literal(input logic [7:0] b);
        lit_buf[0] = b;
        lit_len    = 1;
        held       = b;
    endfunction

    function automatic void encode_byte(input logic [7:0] b, input logic eos);
        int    pos;
        int    lanes;
        word_t w;
        enc_q.delete();
        if (in_rep)
        begin
            if (b == held)
            begin
                rep_len++;
                if (rep_len >= REPEAT_MAX)
                    put_repeat();
            end
            else
            begin
                put_repeat();
                open_literal(b);
            end
        end
        else if (lit_len == 0)
            open_literal(b);
        else if (b == held)
        begin
            put_literal(lit_len - 1);
            lit_len = 0;
            in_rep  = 1'b1;
            rep_len = 2;
        end
        else if (lit_len >= LITERAL_MAX)
        begin
            put_literal(LITERAL_MAX);
            open_literal(b);
        end
        else
        begin
            lit_buf[lit_len] = b;
            lit_len++;
            held = b;
        end
        if (eos)
        begin
            if (in_rep)
                put_repeat();
            put_literal(lit_len);
            lit_len = 0;
            held    = 8'h00;
        end
        pos = 0;
        while (pos < enc_q.size())
        begin
            lanes = enc_q.size() - pos;
            if (lanes > OUT_LANES)
                lanes = OUT_LANES;
            w.lanes = '0;
            for (int j = 0; j < lanes; j++)
                w.lanes[8*j +: 8] = enc_q[pos + j];
            pos    += lanes;
            w.count = CNT_W'(lanes);
            w.last  = (pos >= enc_q.size());
            pending_words.push_back(w);
        end
    endfunction

    task automatic report_fault(input string what, input word_t want);
        fault_count++;
        if (fault_count <= 10)
            $display("%s: expected lanes=%h count=%0d last=%0d, got lanes=%h count=%0d last=%0d",
                     what, want.lanes, want.count, want.last,
                     packed_bytes, byte_count, last_word);
    endtask

    always @(posedge clk)
    begin
        word_t want;
        if (rst_n && word_valid && word_ready)
        begin
            words_seen++;
            if (pending_words.size() == 0)
            begin
                want = '{lanes: '0, count: '0, last: 1'b0};
                report_fault("unexpected word", want);
            end
            else
            begin
                want = pending_words.pop_front();
                if (packed_bytes !== want.lanes || byte_count !== want.count ||
                    last_word !== want.last)
                    report_fault("word mismatch", want);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            data_valid <= 1'b0;
            @(posedge clk);
        end
        data_byte     <= b;
        end_of_stream <= eos;
        data_valid    <= 1'b1;
        do
            @(posedge clk);
        while (!data_ready);
        encode_byte(b, eos);
        requests_sent++;
        if (eos)
            streams_sent++;
    endtask

    task automatic send_stream(ref logic [7:0] bytes_q[$]);
        for (int i = 0; i < bytes_q.size(); i++)
            send_byte(bytes_q[i], i == bytes_q.size() - 1);
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_directed();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b1);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    task automatic test_run_limits();
        logic [7:0] bytes_q[$];
        bytes_q.delete();
        repeat (REPEAT_MAX + 2)
            bytes_q.push_back(8'hC3);
        send_stream(bytes_q);
        bytes_q.delete();
        for (int i = 0; i < LITERAL_MAX; i++)
            bytes_q.push_back(8'(i));
        bytes_q.push_back(8'd200);
        bytes_q.push_back(8'd201);
        send_stream(bytes_q);
    endtask

    task automatic test_random_streams(input int target);
        logic [7:0] bytes_q[$];
        logic [7:0] v;
        int         stop_at;
        int         len;
        int         kind;
        stop_at = requests_sent + target;
        while (requests_sent < stop_at)
        begin
            bytes_q.delete();
            repeat ($urandom_range(1, 6))
            begin
                kind = $urandom_range(0, 9);
                len  = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140)
                                                    : $urandom_range(1, 12);
                if (kind < 4)
                begin
                    v = pick_byte();
                    repeat ((len < 2) ? 2 : len)
                        bytes_q.push_back(v);
                end
                else if (kind < 8)
                begin
                    repeat (len)
                    begin
                        do
                            v = pick_byte();
                        while (bytes_q.size() > 0 && v == bytes_q[$]);
                        bytes_q.push_back(v);
                    end
                end
                else
                begin
                    repeat (len)
                    begin
                        if (bytes_q.size() > 0 && $urandom_range(0, 1))
                            v = bytes_q[$];
                        else
                            v = $urandom_range(0, 1) ? 8'h3C : pick_byte();
                        bytes_q.push_back(v);
                    end
                end
            end
            while (bytes_q.size() > stop_at - requests_sent)
                bytes_q.delete(bytes_q.size() - 1);
            send_stream(bytes_q);
        end
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        data_valid <= 1'b0;
        while (pending_words.size() != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (300)
            @(posedge clk);
        if (pending_words.size() != 0)
        begin
            $display("%0d expected words never arrived", pending_words.size());
            fault_count += pending_words.size();
        end
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct    = 11;
        ready_stall_pct = 83;
        test_directed();
        test_random_streams(50);

        send_gap_pct    = 83;
        ready_stall_pct = 11;
        test_run_limits();
        test_random_streams(50);

        send_gap_pct    = 0;
        ready_stall_pct = 0;
        test_random_streams(50);

        drain_results();
        $display("Sent %0d byte requests in %0d streams, checked %0d encoded words",
                 requests_sent, streams_sent, words_seen);
        $display("Covered directed corners, full-length literal and repeat runs and random streams");
        if (fault_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("FAILURE");
        $finish;
    end

endmodule
